// ===== rtl/facl_pkg.sv =====
// Shared types and constants of the LFU fully associative cache model.
// Used by the sequencer, the scan unit and the top level.
package facl_pkg;

  localparam int unsigned EntriesDef   = 32;
  localparam int unsigned AddrBitsDef  = 32;
  localparam int unsigned CountBitsDef = 32;

  // Fixed port widths
  localparam int unsigned InAddrW = 32;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned TotalW  = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } facl_state_e;

  // Controls from the sequencer to the scan unit and the update logic
  typedef struct packed {
    logic clr;      // new beat accepted, restart the scan
    logic rd_en;    // read tag and count at the scan index
    logic lkp_vld;  // read data is valid this cycle
    logic commit;   // write back and present the result
  } facl_ctl_t;

endpackage

// ===== rtl/facl_ram.sv =====
// Generic RAM with one write port, one read port and registered read data.
// No dependencies.
module facl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/facl_ctrl.sv =====
// Sequencer: walks the entry index once per access and sequences write-back.
// Depends on facl_pkg for the state enum and the control struct.
module facl_ctrl import facl_pkg::*; #(
  parameter int unsigned ENTRIES = EntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       out_free_i,
  output logic                       in_ready_o,
  output facl_ctl_t                  ctl_o,
  output logic [$clog2(ENTRIES)-1:0] rd_idx_o,
  output logic [$clog2(ENTRIES)-1:0] lkp_idx_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  facl_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            lkp_vld_q;
  logic [IdxW-1:0] lkp_idx_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == LastIdx) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_COMMIT;
      ST_COMMIT: if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctl_o.clr     = 1'b0;
    ctl_o.rd_en   = 1'b0;
    ctl_o.commit  = 1'b0;
    ctl_o.lkp_vld = lkp_vld_q;
    idx_d         = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ctl_o.clr  = in_valid_i;
        idx_d      = '0;
      end
      ST_SCAN: begin
        ctl_o.rd_en = 1'b1;
        idx_d       = idx_q + IdxW'(1);
      end
      ST_DRAIN: begin
        idx_d = '0;
      end
      ST_COMMIT: begin
        ctl_o.commit = out_free_i;
      end
      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      lkp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      lkp_vld_q <= ctl_o.rd_en;
    end
  end

  // Index of the entry whose read data shows up next cycle
  always_ff @(posedge clk_i) begin
    lkp_idx_q <= idx_q;
  end

  assign rd_idx_o  = idx_q;
  assign lkp_idx_o = lkp_idx_q;

endmodule

// ===== rtl/facl_scan.sv =====
// Scan unit: one tag compare and one count compare per entry read, tracking
// the first hit, the first empty entry and the least-used entry.
// Depends on facl_pkg for the control struct.
module facl_scan import facl_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned ADDR_BITS  = AddrBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  facl_ctl_t                  ctl_i,
  input  logic [$clog2(ENTRIES)-1:0] lkp_idx_i,
  input  logic                       entry_valid_i,
  input  logic [ADDR_BITS-1:0]       tag_i,
  input  logic [COUNT_BITS-1:0]      cnt_i,
  input  logic [ADDR_BITS-1:0]       addr_i,
  output logic                       hit_o,
  output logic                       evict_o,
  output logic [$clog2(ENTRIES)-1:0] slot_o,
  output logic [COUNT_BITS-1:0]      cnt_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic                  hit_q, empty_q, seen_q;
  logic [IdxW-1:0]       hit_slot_q, empty_slot_q, min_slot_q;
  logic [COUNT_BITS-1:0] hit_cnt_q, min_cnt_q;
  logic [COUNT_BITS-1:0] cnt_eff;
  logic                  match, less;

  // Never-written entries are invalid: mask their contents
  assign cnt_eff = entry_valid_i ? cnt_i : '0;
  assign match   = entry_valid_i && (tag_i == addr_i);
  assign less    = !seen_q || (cnt_eff < min_cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (ctl_i.clr) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (ctl_i.lkp_vld) begin
      seen_q <= 1'b1;
      if (match) hit_q <= 1'b1;
      if (!entry_valid_i) empty_q <= 1'b1;
    end
  end

  // Keep only the first hit and the first empty entry; strict less keeps lowest index
  always_ff @(posedge clk_i) begin
    if (ctl_i.lkp_vld) begin
      if (match && !hit_q) begin
        hit_slot_q <= lkp_idx_i;
        hit_cnt_q  <= cnt_eff;
      end
      if (!entry_valid_i && !empty_q) begin
        empty_slot_q <= lkp_idx_i;
      end
      if (less) begin
        min_slot_q <= lkp_idx_i;
        min_cnt_q  <= cnt_eff;
      end
    end
  end

  always_comb begin
    hit_o   = hit_q;
    evict_o = 1'b0;
    if (hit_q) begin
      slot_o = hit_slot_q;
      cnt_o  = hit_cnt_q;
    end else if (empty_q) begin
      slot_o = empty_slot_q;
      cnt_o  = '0;
    end else begin
      slot_o  = min_slot_q;
      cnt_o   = min_cnt_q;
      evict_o = 1'b1;
    end
  end

endmodule

// ===== rtl/fully_assoc_cache_lfu.sv =====
// Top level of the LFU fully associative cache model.
// Depends on facl_pkg, facl_ram, facl_ctrl and facl_scan.

// Each accepted address is looked up by reading the tag and use-count RAMs
// one entry per cycle through a single read port. The access then passes
// through the scan of all ENTRIES entries, a drain step for the last read to
// land, and a write-back step that registers the result. The next address is
// taken only in the idle state after write-back, so the block takes one
// address at a time; a finished result waits in the output register while
// the next address is scanned, and write-back holds until that register is
// free. No clearing pass is needed after reset.
module fully_assoc_cache_lfu import facl_pkg::*; #(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned ADDR_BITS  = AddrBitsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InAddrW-1:0] block_address_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic [SlotW-1:0]   slot_o,
  output logic               evicted_o,
  output logic [TotalW-1:0]  total_accesses_o,
  output logic [TotalW-1:0]  total_hits_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  facl_ctl_t             ctl;
  logic [IdxW-1:0]       rd_idx, lkp_idx;
  logic                  out_free;
  logic [ENTRIES-1:0]    valid_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [ADDR_BITS+InAddrW-1:0] addr_ext;
  logic [ADDR_BITS-1:0]  tag_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                  res_hit, res_evict;
  logic [IdxW-1:0]       res_slot;
  logic [COUNT_BITS-1:0] res_cnt, cnt_new;
  logic [IdxW+SlotW-1:0] slot_ext;
  logic                  out_valid_q, hit_q, evict_q;
  logic [SlotW-1:0]      slot_q;
  logic [TotalW-1:0]     acc_total_q, hit_total_q;

  assign out_free = !out_valid_q || out_ready_i;

  facl_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .out_free_i(out_free),
    .in_ready_o,
    .ctl_o     (ctl),
    .rd_idx_o  (rd_idx),
    .lkp_idx_o (lkp_idx)
  );

  // Tag is the low ADDR_BITS of the address, zero-extended if wider
  assign addr_ext = {{ADDR_BITS{1'b0}}, block_address_i};

  always_ff @(posedge clk_i) begin
    if (ctl.clr) begin
      addr_q <= addr_ext[ADDR_BITS-1:0];
    end
  end

  facl_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(ENTRIES)
  ) u_tag_ram (
    .clk_i,
    .we_i   (ctl.commit && !res_hit),
    .waddr_i(res_slot),
    .wdata_i(addr_q),
    .re_i   (ctl.rd_en),
    .raddr_i(rd_idx),
    .rdata_o(tag_rd)
  );

  facl_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(ENTRIES)
  ) u_cnt_ram (
    .clk_i,
    .we_i   (ctl.commit),
    .waddr_i(res_slot),
    .wdata_i(cnt_new),
    .re_i   (ctl.rd_en),
    .raddr_i(rd_idx),
    .rdata_o(cnt_rd)
  );

  facl_scan #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_scan (
    .clk_i,
    .rst_ni,
    .ctl_i        (ctl),
    .lkp_idx_i    (lkp_idx),
    .entry_valid_i(valid_q[lkp_idx]),
    .tag_i        (tag_rd),
    .cnt_i        (cnt_rd),
    .addr_i       (addr_q),
    .hit_o        (res_hit),
    .evict_o      (res_evict),
    .slot_o       (res_slot),
    .cnt_o        (res_cnt)
  );

  // Saturating use-count bump
  assign cnt_new  = (&res_cnt) ? res_cnt : res_cnt + COUNT_BITS'(1);
  assign slot_ext = {{SlotW{1'b0}}, res_slot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      acc_total_q <= '0;
      hit_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl.commit) begin
        valid_q[res_slot] <= 1'b1;
        if (!(&acc_total_q)) acc_total_q <= acc_total_q + TotalW'(1);
        if (res_hit && !(&hit_total_q)) hit_total_q <= hit_total_q + TotalW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.commit) begin
      hit_q   <= res_hit;
      evict_q <= res_evict;
      slot_q  <= slot_ext[SlotW-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_q;
  assign slot_o           = slot_q;
  assign evicted_o        = evict_q;
  // Totals only change at write-back, which waits for a free output register
  assign total_accesses_o = acc_total_q;
  assign total_hits_o     = hit_total_q;

endmodule

// ===== rtl/facl_checker.sv =====
// Port-level checks for the LFU fully associative cache model, bound to the top.
// Depends on facl_pkg for port widths.
module facl_checker import facl_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              hit_o,
  input logic [SlotW-1:0]  slot_o,
  input logic              evicted_o,
  input logic [TotalW-1:0] total_accesses_o,
  input logic [TotalW-1:0] total_hits_o
);

  // Held result beat keeps its hit, slot, eviction flag and access total
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_o) && $stable(slot_o)
      && $stable(evicted_o) && $stable(total_accesses_o))
    else $error("result beat changed while stalled");

  // One access at a time: ready drops right after an accepted beat
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second address taken during a lookup");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("hit reported with eviction");

  // Hits never outnumber accesses; a hit implies a nonzero hit total
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (total_hits_o <= total_accesses_o) && (!hit_o || total_hits_o != '0))
    else $error("inconsistent running totals");

endmodule

bind fully_assoc_cache_lfu facl_checker u_facl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .slot_o          (slot_o),
  .evicted_o       (evicted_o),
  .total_accesses_o(total_accesses_o),
  .total_hits_o    (total_hits_o)
);
